// ===== hw/rtl/fra_pkg.sv =====
// fra_pkg: shared types, codes and helpers of the rational-number unit
// no dependencies; imported by every module of fraction_arith_reduce
`timescale 1ns / 1ps
`default_nettype none
package fra_pkg;

    localparam int VALUE_BITS = 16;
    localparam int NUM_BITS   = 33;
    localparam int DEN_BITS   = 32;
    localparam int PROD_BITS  = 2 * VALUE_BITS;
    localparam int SHIFT_BITS = $clog2(NUM_BITS + 1);

    // request operation codes
    localparam logic [1:0] OP_BUILD = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_MUL   = 2'd2;
    localparam logic [1:0] OP_CMP   = 2'd3;

    // work classes decided at the front
    localparam logic [2:0] KIND_ZERO  = 3'd0;
    localparam logic [2:0] KIND_CMP   = 3'd1;
    localparam logic [2:0] KIND_BUILD = 3'd2;
    localparam logic [2:0] KIND_ADD   = 3'd3;
    localparam logic [2:0] KIND_MUL   = 3'd4;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [VALUE_BITS-1:0] a_num;
        logic [VALUE_BITS-1:0] a_den;
        logic [VALUE_BITS-1:0] b_num;
        logic [VALUE_BITS-1:0] b_den;
    } req_t;

    typedef struct packed {
        logic [NUM_BITS-1:0] res_num;
        logic [DEN_BITS-1:0] res_den;
        logic                res_empty;
        logic                is_equal;
    } res_t;

    // classified item between front and back
    typedef struct packed {
        logic [2:0]            kind;
        logic                  eq;
        logic [VALUE_BITS-1:0] a_num;
        logic [VALUE_BITS-1:0] a_den;
        logic [VALUE_BITS-1:0] b_num;
        logic [VALUE_BITS-1:0] b_den;
    } cmd_t;

    // one restoring division step: returns {new remainder, quotient bit}
    function automatic logic [NUM_BITS:0] div_step(
        input logic [NUM_BITS-1:0] rem,
        input logic                bit_in,
        input logic [NUM_BITS-1:0] dvs
    );
        logic [NUM_BITS:0] pre;
        logic [NUM_BITS:0] dif;
        pre = {rem, bit_in};
        dif = pre - {1'b0, dvs};
        if (pre >= {1'b0, dvs})
            return {dif[NUM_BITS-1:0], 1'b1};
        else
            return {pre[NUM_BITS-1:0], 1'b0};
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fraction_arith_reduce.sv =====
// fraction_arith_reduce: rational-number unit, one result item per request
// paths: compare/empty direct; mul: multiplier; build: gcd, divider; add: all three
// gcd: binary gcd, run until one operand is zero, then scaled by the common power of two
// throughput: one item at a time in the back end; gcd loop and 33-step divider set the rate
// a two-entry queue lets the front take items while the back is busy
// reset: rst_n asynchronous active low clears queue, sequencer and output valid
`timescale 1ns / 1ps
`default_nettype none
module fraction_arith_reduce (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                req_valid,
    output logic               req_ready,
    input  wire fra_pkg::req_t req,
    output logic               res_valid,
    input  wire                res_ready,
    output fra_pkg::res_t      res
);
    import fra_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_full;
    logic q_nonempty;
    logic q_pop;

    assign req_ready = !q_full;

    // classification
    fra_front u_front (
        .req (req),
        .cmd (front_cmd)
    );

    // command queue
    fra_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (req_valid && req_ready),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .head     (head_cmd)
    );

    // execution
    fra_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_nonempty),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/fra_front.sv =====
// fra_front: takes request items and classifies them into work commands
// depends on fra_pkg
`timescale 1ns / 1ps
`default_nettype none
module fra_front (
    input  wire fra_pkg::req_t req,
    output fra_pkg::cmd_t      cmd
);
    import fra_pkg::*;

    logic a_empty;
    logic b_empty;

    // empty operand detection
    assign a_empty = (req.a_num == '0) && (req.a_den == '0);
    assign b_empty = (req.b_num == '0) && (req.b_den == '0);

    // classify by operation and operand emptiness
    always_comb
    begin
        cmd.a_num = req.a_num;
        cmd.a_den = req.a_den;
        cmd.b_num = req.b_num;
        cmd.b_den = req.b_den;
        cmd.eq    = 1'b0;
        cmd.kind  = KIND_ZERO;
        unique case (req.req_type)
            OP_BUILD:
            begin
                if (req.a_num != '0 && req.a_den != '0)
                    cmd.kind = KIND_BUILD;
            end
            OP_ADD:
            begin
                if (!a_empty && !b_empty)
                    cmd.kind = KIND_ADD;
            end
            OP_MUL:
            begin
                if (!a_empty && !b_empty)
                    cmd.kind = KIND_MUL;
            end
            OP_CMP:
            begin
                cmd.kind = KIND_CMP;
                cmd.eq   = !a_empty && !b_empty
                           && req.a_num == req.b_num && req.a_den == req.b_den;
            end
            default: cmd.kind = KIND_ZERO;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fra_queue.sv =====
// fra_queue: two-entry command queue between front and back
// depends on fra_pkg
`timescale 1ns / 1ps
`default_nettype none
module fra_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  wire fra_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire                pop,
    output logic               nonempty,
    output fra_pkg::cmd_t      head
);
    import fra_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign head     = mem_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fra_back.sv =====
// fra_back: executes commands: shared multiplier, binary gcd, division by gcd
// depends on fra_pkg
`timescale 1ns / 1ps
`default_nettype none
module fra_back (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cmd_valid,
    input  wire fra_pkg::cmd_t cmd,
    output logic               cmd_pop,
    output logic               res_valid,
    input  wire                res_ready,
    output fra_pkg::res_t      res
);
    import fra_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_GCD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic [SHIFT_BITS-1:0] DIV_LAST = SHIFT_BITS'(NUM_BITS - 1);

    logic [2:0]            state_reg;
    logic                  cmp_reg;
    logic                  eq_reg;
    logic                  add_reg;
    logic [1:0]            step_reg;
    cmd_t                  c_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic [NUM_BITS-1:0]   num_reg;
    logic [NUM_BITS-1:0]   den_reg;
    logic [NUM_BITS-1:0]   gx_reg;
    logic [NUM_BITS-1:0]   gy_reg;
    logic [SHIFT_BITS-1:0] k_reg;
    logic [NUM_BITS-1:0]   g_reg;
    logic [NUM_BITS-1:0]   rn_reg;
    logic [NUM_BITS-1:0]   rd_reg;
    logic [SHIFT_BITS-1:0] cnt_reg;
    logic                  out_valid_reg;
    res_t                  out_reg;

    logic [VALUE_BITS-1:0] mx;
    logic [VALUE_BITS-1:0] my;
    logic [PROD_BITS-1:0]  mprod;
    logic [NUM_BITS:0]     stn;
    logic [NUM_BITS:0]     std;
    logic                  out_free;

    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign out_free  = !out_valid_reg || res_ready;
    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid;

    // operand select for the shared multiplier
    always_comb
    begin
        mx = c_reg.a_den;
        my = c_reg.b_den;
        unique case (step_reg)
            2'd0:
            begin
                mx = c_reg.a_num;
                my = add_reg ? c_reg.b_den : c_reg.b_num;
            end
            2'd1:
            begin
                mx = c_reg.a_den;
                my = add_reg ? c_reg.b_num : c_reg.b_den;
            end
            default:
            begin
                mx = c_reg.a_den;
                my = c_reg.b_den;
            end
        endcase
    end
    assign mprod = mx * my;

    // division steps for numerator and denominator
    assign stn = div_step(rn_reg, num_reg[NUM_BITS-1], g_reg);
    assign std = div_step(rd_reg, den_reg[NUM_BITS-1], g_reg);

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                c_reg    <= cmd;
                cmp_reg  <= (cmd.kind == KIND_CMP);
                eq_reg   <= cmd.eq;
                add_reg  <= (cmd.kind == KIND_ADD);
                step_reg <= 2'd0;
                num_reg  <= NUM_BITS'(cmd.a_num);
                den_reg  <= NUM_BITS'(cmd.a_den);
                gx_reg   <= NUM_BITS'(cmd.a_num);
                gy_reg   <= NUM_BITS'(cmd.a_den);
                k_reg    <= '0;
                if (cmd.kind == KIND_ZERO || cmd.kind == KIND_CMP)
                begin
                    num_reg <= '0;
                    den_reg <= '0;
                end
            end
            S_MUL:
            begin
                step_reg <= step_reg + 2'd1;
                prod_reg <= mprod;
                unique case (step_reg)
                    2'd0: ;
                    2'd1: num_reg <= NUM_BITS'(prod_reg);
                    2'd2:
                    begin
                        if (add_reg)
                            num_reg <= num_reg + NUM_BITS'(prod_reg);
                        else
                            den_reg <= NUM_BITS'(prod_reg);
                    end
                    default:
                    begin
                        den_reg <= NUM_BITS'(prod_reg);
                        gx_reg  <= num_reg;
                        gy_reg  <= NUM_BITS'(prod_reg);
                        k_reg   <= '0;
                    end
                endcase
            end
            S_GCD:
            begin
                // binary gcd, one step per cycle
                priority if (gx_reg == '0 || gy_reg == '0)
                begin
                    g_reg   <= (gx_reg == '0) ? (gy_reg << k_reg) : (gx_reg << k_reg);
                    rn_reg  <= '0;
                    rd_reg  <= '0;
                    cnt_reg <= '0;
                end
                else if (!gx_reg[0] && !gy_reg[0])
                begin
                    gx_reg <= gx_reg >> 1;
                    gy_reg <= gy_reg >> 1;
                    k_reg  <= k_reg + 1'b1;
                end
                else if (!gx_reg[0])
                    gx_reg <= gx_reg >> 1;
                else if (!gy_reg[0])
                    gy_reg <= gy_reg >> 1;
                else if (gx_reg >= gy_reg)
                    gx_reg <= gx_reg - gy_reg;
                else
                    gy_reg <= gy_reg - gx_reg;
            end
            S_DIV:
            begin
                // quotient bits shift into the dividend registers
                rn_reg  <= stn[NUM_BITS:1];
                rd_reg  <= std[NUM_BITS:1];
                num_reg <= {num_reg[NUM_BITS-2:0], stn[0]};
                den_reg <= {den_reg[NUM_BITS-2:0], std[0]};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        unique case (cmd.kind)
                            KIND_BUILD:          state_reg <= S_GCD;
                            KIND_ADD, KIND_MUL:  state_reg <= S_MUL;
                            default:             state_reg <= S_FIN;
                        endcase
                    end
                end
                S_MUL:
                begin
                    if (step_reg == 2'd2 && !add_reg)
                        state_reg <= S_FIN;
                    else if (step_reg == 2'd3)
                    begin
                        // zero part keeps the value as is
                        if (num_reg == '0 || prod_reg == '0)
                            state_reg <= S_FIN;
                        else
                            state_reg <= S_GCD;
                    end
                end
                S_GCD:
                begin
                    if (gx_reg == '0 || gy_reg == '0)
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == DIV_LAST)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && out_free)
        begin
            out_reg.res_num   <= num_reg;
            out_reg.res_den   <= den_reg[DEN_BITS-1:0];
            out_reg.res_empty <= !cmp_reg && num_reg == '0 && den_reg == '0;
            out_reg.is_equal  <= cmp_reg && eq_reg;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fra_checker.sv =====
// fra_checker: port-level assertions for fraction_arith_reduce, bound to the top
// depends on fra_pkg
`timescale 1ns / 1ps
`default_nettype none
module fra_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                req_ready,
    input wire                res_valid,
    input wire                res_ready,
    input wire fra_pkg::res_t res
);
    import fra_pkg::*;

    // stalled result item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result item changed while stalled");

    // empty flag only with zero parts
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.res_empty |-> res.res_num == '0 && res.res_den == '0
                                        && !res.is_equal)
        else $error("empty flag with nonzero parts");

    // equality result carries no fraction
    a_eq: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.is_equal |-> res.res_num == '0 && res.res_den == '0)
        else $error("compare result with fraction parts");

    // no result right after reset release
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result valid out of reset");

    // empty queue takes an item right after reset
    a_ready: assert property (@(posedge clk)
        !rst_n |=> req_ready)
        else $error("request not ready out of reset");

endmodule

bind fraction_arith_reduce fra_checker u_fra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
`default_nettype wire

// ===== tb/fraction_arith_reduce_tb.sv =====
// fraction_arith_reduce_tb: self-checking bench for the rational-number unit
// depends on fra_pkg and fraction_arith_reduce; predicts each result item in a queue
`timescale 1ns / 1ps
module fraction_arith_reduce_tb;
    import fra_pkg::*;

    localparam longint CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic res_valid;
    logic res_ready;
    res_t res;

    res_t   pending_q[$];
    int     mismatch_count = 0;
    int     items_sent;
    int     items_checked = 0;
    longint cycle_count = 0;
    int     send_idle_pct;
    int     stall_pct;

    fraction_arith_reduce dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // euclid gcd, zero part gives one
    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned r;
        if (x == 0 || y == 0)
            return 1;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // expected result of one request
    function automatic res_t fraction_result(req_t r);
        res_t            o;
        longint unsigned an, ad, bn, bd, rn, rd, g;
        logic            a_empty, b_empty, is_cmp, eq;
        an = r.a_num;
        ad = r.a_den;
        bn = r.b_num;
        bd = r.b_den;
        a_empty = (an == 0 && ad == 0);
        b_empty = (bn == 0 && bd == 0);
        rn = 0;
        rd = 0;
        eq = 1'b0;
        is_cmp = 1'b0;
        case (r.req_type)
            OP_BUILD:
            begin
                if (an > 0 && ad > 0)
                begin
                    g = gcd_of(an, ad);
                    rn = an / g;
                    rd = ad / g;
                end
            end
            OP_ADD:
            begin
                if (!a_empty && !b_empty)
                begin
                    rn = an * bd + ad * bn;
                    rd = ad * bd;
                    g = gcd_of(rn, rd);
                    rn = rn / g;
                    rd = rd / g;
                end
            end
            OP_MUL:
            begin
                if (!a_empty && !b_empty)
                begin
                    rn = an * bn;
                    rd = ad * bd;
                end
            end
            default:
            begin
                is_cmp = 1'b1;
                eq = !a_empty && !b_empty && an == bn && ad == bd;
            end
        endcase
        o.res_num = rn[NUM_BITS-1:0];
        o.res_den = rd[DEN_BITS-1:0];
        o.res_empty = !is_cmp && rn == 0 && rd == 0;
        o.is_equal = eq;
        return o;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("mismatch on %s at item %0d: got %0h expected %0h",
                 field, items_checked, got, want);
        mismatch_count++;
    endtask

    // send one item, idling at random first
    task automatic send_item(req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_q.push_back(fraction_result(r));
        items_sent++;
    endtask

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ready <= 1'b1;
        else
            res_ready <= ($urandom_range(99) >= stall_pct);
    end

    // check each accepted result item
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_q.size() == 0)
            begin
                report_mismatch("unexpected item", res.res_num, 0);
            end
            else
            begin
                want = pending_q.pop_front();
                if (res.res_num !== want.res_num)
                    report_mismatch("res_num", res.res_num, want.res_num);
                if (res.res_den !== want.res_den)
                    report_mismatch("res_den", res.res_den, want.res_den);
                if (res.res_empty !== want.res_empty)
                    report_mismatch("res_empty", res.res_empty, want.res_empty);
                if (res.is_equal !== want.is_equal)
                    report_mismatch("is_equal", res.is_equal, want.is_equal);
            end
            items_checked++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout with %0d items outstanding", pending_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic req_t make_req(logic [1:0] op, int an, int ad, int bn, int bd);
        req_t r;
        r.req_type = op;
        r.a_num = VALUE_BITS'(an);
        r.a_den = VALUE_BITS'(ad);
        r.b_num = VALUE_BITS'(bn);
        r.b_den = VALUE_BITS'(bd);
        return r;
    endfunction

    // random operand part, biased to small, zero and full-scale values
    function automatic logic [VALUE_BITS-1:0] rand_part();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return VALUE_BITS'($urandom_range(12));
            4, 5: return VALUE_BITS'($urandom_range(255));
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [1:0] op;
        for (int k = 0; k < 4; k++)
        begin
            op = k[1:0];
            send_item(make_req(op, 0, 0, 3, 4));
            send_item(make_req(op, 5, 7, 0, 0));
            send_item(make_req(op, 65535, 65535, 65535, 65535));
            send_item(make_req(op, 6, 4, 6, 4));
        end
        // zero parts, sum of zero-denominator fractions, coprime extremes, unreduced compare, large common factor
        send_item(make_req(OP_BUILD, 0, 9, 0, 0));
        send_item(make_req(OP_BUILD, 9, 0, 0, 0));
        send_item(make_req(OP_ADD, 3, 0, 4, 0));
        send_item(make_req(OP_ADD, 0, 5, 0, 7));
        send_item(make_req(OP_ADD, 65535, 65534, 65533, 65521));
        send_item(make_req(OP_MUL, 0, 3, 2, 0));
        send_item(make_req(OP_CMP, 1, 2, 2, 4));
        send_item(make_req(OP_BUILD, 43690, 21845, 0, 0));
    endtask

    task automatic test_random(int count);
        req_t r;
        for (int i = 0; i < count; i++)
        begin
            r.req_type = 2'($urandom_range(3));
            r.a_num = rand_part();
            r.a_den = rand_part();
            if (r.req_type == OP_CMP && $urandom_range(1))
            begin
                r.b_num = r.a_num;
                r.b_den = r.a_den;
            end
            else
            begin
                r.b_num = rand_part();
                r.b_den = rand_part();
            end
            send_item(r);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        items_sent = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(330);
        send_idle_pct = 69;
        test_random(330);
        send_idle_pct = 0;
        stall_pct = 69;
        test_random(330);
        send_idle_pct = 36;
        stall_pct = 36;
        test_random(330);
        stall_pct = 0;
        wait_drained();

        $display("sent %0d requests over all four operations, checked %0d results",
                 items_sent, items_checked);
        $display("phases: free running, sender idling, receiver stalling, both");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
